// ===== src/mimo_stream_and_mcs_select_unit_defines.svh =====
// Assertion macros for the stream and MCS selector.
`ifndef MIMO_STREAM_AND_MCS_SELECT_UNIT_DEFINES_SVH
`define MIMO_STREAM_AND_MCS_SELECT_UNIT_DEFINES_SVH

// ante true implies cons in the same cycle
`define MSMCS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// cond holds at every edge out of reset
`define MSMCS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

`endif

// ===== src/msmcs_pkg.sv =====
package msmcs_pkg;

  localparam int ANTENNAS = 4;
  localparam int STATES   = 9;

  localparam int InStW   = 4;
  localparam int StW     = $clog2(STATES);
  localparam int FieldW  = 16;
  localparam int RegW    = 64;
  localparam int FieldsPerReg = RegW / FieldW;
  localparam int MulW    = FieldW + $clog2(ANTENNAS + 1);
  localparam int CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_THR_LO,
    REG_THR_HI,
    REG_RATE_LO,
    REG_RATE_HI
  } cfg_reg_t;

  typedef logic [StW-1:0] state_t;

  typedef struct packed {
    logic [InStW-1:0] antenna_state_0;
    logic [InStW-1:0] antenna_state_1;
    logic [InStW-1:0] antenna_state_2;
    logic [InStW-1:0] antenna_state_3;
  } in_word_t;

  typedef struct packed {
    logic [4:0]  mcs_with_streams;
    logic [2:0]  stream_count;
    logic [2:0]  mcs_per_stream;
    logic [17:0] aggregate_rate;
  } out_word_t;

  // 16-bit field of state st from a low/high register pair; state 0 and
  // states without a field read as zero
  function automatic logic [FieldW-1:0] field_of(logic [RegW-1:0] lo,
                                                 logic [RegW-1:0] hi,
                                                 state_t st);
    int idx;
    logic [FieldW-1:0] f;
    f = '0;
    idx = int'(st) - 1;
    if (st != '0 && idx < 2 * FieldsPerReg) begin
      if (idx < FieldsPerReg) begin
        f = lo[FieldW*idx +: FieldW];
      end else begin
        f = hi[FieldW*(idx - FieldsPerReg) +: FieldW];
      end
    end
    return f;
  endfunction

endpackage

// ===== src/mimo_stream_and_mcs_select_unit.sv =====
// Channel  | Signals                            | Direction | Word
// states   | states_valid/_ready, states        | in        | four antenna states
// choice   | choice_valid/_ready, choice        | out       | streams, mcs, rate
// cfg      | cfg_we, cfg_index, cfg_data        | in        | 64-bit table write
//
// Five register stages: clamp+sort, threshold compare, raise encode,
// rate products, best-choice select into the output register.
// One word per cycle unless the output stalls; choice_valid comes from the stage-5 valid bit.
// Each stage holds only while the one after it is full and stalled, so
// bubbles collapse and a stalled output still lets earlier stages fill.
// rst clears valid bits and the four table registers.
`include "mimo_stream_and_mcs_select_unit_defines.svh"

module mimo_stream_and_mcs_select_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              states_valid,
  output logic                              states_ready,
  input  msmcs_pkg::in_word_t               states,
  output logic                              choice_valid,
  input  logic                              choice_ready,
  output msmcs_pkg::out_word_t              choice,
  input  logic                              cfg_we,
  input  logic [msmcs_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [msmcs_pkg::RegW-1:0]        cfg_data
);
  import msmcs_pkg::*;

  logic [RegW-1:0] thr_lo, thr_hi, rate_lo, rate_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_lo  <= '0;
      thr_hi  <= '0;
      rate_lo <= '0;
      rate_hi <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_THR_LO:  thr_lo  <= cfg_data;
        REG_THR_HI:  thr_hi  <= cfg_data;
        REG_RATE_LO: rate_lo <= cfg_data;
        REG_RATE_HI: rate_hi <= cfg_data;
      endcase
    end
  end

  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5 || choice_ready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign states_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= states_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // stage 1: clamp, zero detect, odd-even transposition sort
  logic [ANTENNAS-1:0][InStW-1:0] raw;
  state_t [ANTENNAS-1:0] srt;
  state_t                tmp;
  logic                  zero_c;

  assign raw = {states.antenna_state_0, states.antenna_state_1,
                states.antenna_state_2, states.antenna_state_3};

  always_comb begin
    zero_c = 1'b1;
    tmp = '0;
    for (int i = 0; i < ANTENNAS; i++) begin
      if (raw[ANTENNAS-1-i] > InStW'(STATES - 1)) begin
        srt[i] = StW'(STATES - 1);
      end else begin
        srt[i] = StW'(raw[ANTENNAS-1-i]);
      end
      if (srt[i] != '0) zero_c = 1'b0;
    end
    for (int p = 0; p < ANTENNAS; p++) begin
      for (int i = p % 2; i + 1 < ANTENNAS; i += 2) begin
        if (srt[i] > srt[i+1]) begin
          tmp = srt[i];
          srt[i] = srt[i+1];
          srt[i+1] = tmp;
        end
      end
    end
  end

  state_t [ANTENNAS-1:0] st1;
  logic                  zero1;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      st1   <= srt;
      zero1 <= zero_c;
    end
  end

  // stage 2: raise candidates, N*thr[s] >= d*thr[cand] for cand > s
  logic [ANTENNAS-1:0][STATES-1:0] ok_c;
  logic [MulW-1:0] lhs;

  always_comb begin
    ok_c = '0;
    lhs = '0;
    for (int i = 1; i < ANTENNAS; i++) begin
      lhs = MulW'(ANTENNAS) * MulW'(field_of(thr_lo, thr_hi, st1[i]));
      for (int c = 1; c < STATES; c++) begin
        ok_c[i][c] = (StW'(c) > st1[i]) &&
          (lhs >= MulW'(ANTENNAS - i) * MulW'(field_of(thr_lo, thr_hi, StW'(c))));
      end
    end
  end

  state_t [ANTENNAS-1:0]          st2;
  logic [ANTENNAS-1:0][STATES-1:0] ok2;
  logic                            zero2;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      st2   <= st1;
      ok2   <= ok_c;
      zero2 <= zero1;
    end
  end

  // stage 3: highest passing candidate, else the antenna's own state
  state_t [ANTENNAS-1:0] x_c;

  always_comb begin
    for (int i = 0; i < ANTENNAS; i++) begin
      x_c[i] = st2[i];
      for (int c = 1; c < STATES; c++) begin
        if (ok2[i][c]) x_c[i] = StW'(c);
      end
    end
  end

  state_t [ANTENNAS-1:0] x3;
  logic                  zero3;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      x3    <= x_c;
      zero3 <= zero2;
    end
  end

  // stage 4: d*rate[x] for d = N-i
  logic [ANTENNAS-1:0][MulW-1:0] prod_c;

  always_comb begin
    for (int i = 0; i < ANTENNAS; i++) begin
      prod_c[i] = MulW'(ANTENNAS - i) * MulW'(field_of(rate_lo, rate_hi, x3[i]));
    end
  end

  state_t [ANTENNAS-1:0]         x4;
  logic [ANTENNAS-1:0][MulW-1:0] prod4;
  logic                          zero4;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      x4    <= x3;
      prod4 <= prod_c;
      zero4 <= zero3;
    end
  end

  // stage 5: largest product, ties keep more streams
  logic [MulW-1:0] best_prod;
  state_t          best_x;
  logic [2:0]      best_d;
  logic [2:0]      mcs;
  out_word_t       choice_next;

  always_comb begin
    best_prod = prod4[0];
    best_x    = x4[0];
    best_d    = 3'(ANTENNAS);
    for (int i = 1; i < ANTENNAS; i++) begin
      if (prod4[i] > best_prod) begin
        best_prod = prod4[i];
        best_x    = x4[i];
        best_d    = 3'(ANTENNAS - i);
      end
    end
    mcs = (best_x == '0) ? 3'd0 : 3'(best_x - StW'(1));
    choice_next.stream_count     = best_d;
    choice_next.mcs_per_stream   = mcs;
    choice_next.mcs_with_streams = 5'(mcs) + (5'(best_d - 3'd1) << 3);
    choice_next.aggregate_rate   = best_prod[17:0];
    if (zero4) begin
      choice_next.stream_count     = 3'd1;
      choice_next.mcs_per_stream   = 3'd0;
      choice_next.mcs_with_streams = 5'd0;
      choice_next.aggregate_rate   = 18'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      choice <= choice_next;
    end
  end

  assign choice_valid = v5;

  `MSMCS_ASSERT_IMP(a_full_when_blocked, !states_ready,
    v1 && v2 && v3 && v4 && choice_valid && !choice_ready,
    "input blocked while pipeline has room")
  `MSMCS_ASSERT_IMP(a_index_packing, choice_valid,
    choice.mcs_with_streams == (5'(choice.mcs_per_stream) + (5'(choice.stream_count) << 3) - 5'd8),
    "combined index disagrees with stream count and mcs")
  `MSMCS_ASSERT_ALWAYS(a_stream_range,
    !choice_valid || (choice.stream_count != 3'd0 && choice.stream_count <= 3'(ANTENNAS)),
    "stream count out of range")

endmodule

// ===== tb/mimo_stream_and_mcs_select_unit_tb.sv =====
`timescale 1ns / 100ps

module mimo_stream_and_mcs_select_unit_tb;
  import msmcs_pkg::*;

  localparam int TopState      = STATES - 1;
  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles  = 10;

  class mcs_choice_board;
    logic [RegW-1:0] thr_lo, thr_hi, rate_lo, rate_hi;
    out_word_t       expected_choices[$];
    int              checked;
    int              mismatches;

    function new();
      thr_lo     = '0;
      thr_hi     = '0;
      rate_lo    = '0;
      rate_hi    = '0;
      checked    = 0;
      mismatches = 0;
    endfunction

    function void set_table(cfg_reg_t r, logic [RegW-1:0] v);
      case (r)
        REG_THR_LO:  thr_lo  = v;
        REG_THR_HI:  thr_hi  = v;
        REG_RATE_LO: rate_lo = v;
        REG_RATE_HI: rate_hi = v;
        default: ;
      endcase
    endfunction

    function int entry(logic [RegW-1:0] lo, logic [RegW-1:0] hi, int st);
      logic [2*RegW-1:0] both;
      both = {hi, lo};
      if (st == 0) return 0;
      return int'(both[FieldW*(st-1) +: FieldW]);
    endfunction

    function out_word_t choose(in_word_t w);
      int        s[ANTENNAS];
      int        i, j, c, d, x, tmp, lhs, prod;
      int        best_d, best_x, best_prod, mcs;
      out_word_t o;
      s[0] = (w.antenna_state_0 > TopState) ? TopState : int'(w.antenna_state_0);
      s[1] = (w.antenna_state_1 > TopState) ? TopState : int'(w.antenna_state_1);
      s[2] = (w.antenna_state_2 > TopState) ? TopState : int'(w.antenna_state_2);
      s[3] = (w.antenna_state_3 > TopState) ? TopState : int'(w.antenna_state_3);
      if ((s[0] | s[1] | s[2] | s[3]) == 0) begin
        o.mcs_with_streams = '0;
        o.stream_count     = 3'd1;
        o.mcs_per_stream   = '0;
        o.aggregate_rate   = '0;
        return o;
      end
      for (i = 0; i < ANTENNAS - 1; i++) begin
        for (j = 0; j < ANTENNAS - 1 - i; j++) begin
          if (s[j] > s[j+1]) begin
            tmp    = s[j];
            s[j]   = s[j+1];
            s[j+1] = tmp;
          end
        end
      end
      best_d    = ANTENNAS;
      best_x    = s[0];
      best_prod = ANTENNAS * entry(rate_lo, rate_hi, s[0]);
      for (i = 1; i < ANTENNAS; i++) begin
        d   = ANTENNAS - i;
        x   = s[i];
        lhs = ANTENNAS * entry(thr_lo, thr_hi, s[i]);
        // keep the highest raise that still meets the threshold
        for (c = s[i] + 1; c <= TopState; c++) begin
          if (lhs >= d * entry(thr_lo, thr_hi, c)) x = c;
        end
        prod = d * entry(rate_lo, rate_hi, x);
        if (prod > best_prod) begin
          best_prod = prod;
          best_d    = d;
          best_x    = x;
        end
      end
      mcs = (best_x == 0) ? 0 : best_x - 1;
      o.mcs_with_streams = 5'(mcs + 8 * (best_d - 1));
      o.stream_count     = 3'(best_d);
      o.mcs_per_stream   = 3'(mcs);
      o.aggregate_rate   = 18'(best_prod);
      return o;
    endfunction

    function void note_states(in_word_t w);
      expected_choices.push_back(choose(w));
    endfunction

    function void check_choice(out_word_t got);
      out_word_t want;
      if (expected_choices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected choice word %h", got);
        return;
      end
      want = expected_choices.pop_front();
      checked++;
      if (got.mcs_with_streams !== want.mcs_with_streams ||
          got.stream_count !== want.stream_count ||
          got.mcs_per_stream !== want.mcs_per_stream ||
          got.aggregate_rate !== want.aggregate_rate) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: choice %0d exp idx=%0d d=%0d mcs=%0d rate=%0d got idx=%0d d=%0d mcs=%0d rate=%0d",
                   checked, want.mcs_with_streams, want.stream_count, want.mcs_per_stream,
                   want.aggregate_rate, got.mcs_with_streams, got.stream_count,
                   got.mcs_per_stream, got.aggregate_rate);
      end
    endfunction

    function int pending();
      return expected_choices.size();
    endfunction
  endclass

  logic            clk          = 1'b0;
  logic            rst          = 1'b1;
  logic            states_valid = 1'b0;
  logic            states_ready;
  in_word_t        states       = '0;
  logic            choice_valid;
  logic            choice_ready = 1'b0;
  out_word_t       choice;
  logic            cfg_we       = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [RegW-1:0] cfg_data     = '0;

  mcs_choice_board board = new();
  bit  idle_on     = 1'b1;
  int  words_sent  = 0;
  int  loads       = 0;
  int  idle_cycles = 0;

  // extremes, saturating states, single live antennas, ties
  logic [15:0] directed_pats [12] = '{16'h0000, 16'h8888, 16'hFFFF, 16'h1000,
                                      16'h0008, 16'h9ABC, 16'h1234, 16'h8111,
                                      16'h4444, 16'hDE07, 16'h1188, 16'h2050};

  mimo_stream_and_mcs_select_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .states_valid (states_valid),
    .states_ready (states_ready),
    .states       (states),
    .choice_valid (choice_valid),
    .choice_ready (choice_ready),
    .choice       (choice),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (choice_valid && choice_ready) board.check_choice(choice);
      if ((states_valid && states_ready) || (choice_valid && choice_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no word moved for %0d cycles", WatchdogLimit);
        $display("mimo_stream_and_mcs_select_unit verification failed");
        $finish;
      end
    end
  end

  // receiver stalls in bursts
  initial begin
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        choice_ready = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      choice_ready = 1'b1;
    end
  end

  function automatic logic [InStW-1:0] rand_state();
    if ($urandom_range(0, 11) == 11) return InStW'($urandom_range(TopState + 1, 15));
    return InStW'($urandom_range(0, TopState));
  endfunction

  task automatic send_states(in_word_t w);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      states_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    states_valid = 1'b1;
    states       = w;
    do @(posedge clk); while (!states_ready);
    board.note_states(w);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    states_valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [RegW-1:0] v);
    cfg_we    = 1'b1;
    cfg_index = r;
    cfg_data  = v;
    @(negedge clk);
    cfg_we = 1'b0;
    board.set_table(r, v);
  endtask

  task automatic load_tables(logic [2*RegW-1:0] thr, logic [2*RegW-1:0] rate);
    wait_drained();
    write_reg(REG_THR_LO, thr[RegW-1:0]);
    write_reg(REG_THR_HI, thr[2*RegW-1:RegW]);
    write_reg(REG_RATE_LO, rate[RegW-1:0]);
    write_reg(REG_RATE_HI, rate[2*RegW-1:RegW]);
    loads++;
  endtask

  task automatic run_random(int n, bit idle_allowed);
    in_word_t w;
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0) idle_on = idle_allowed && ($urandom_range(0, 3) != 0);
      if (idle_allowed && i == n / 2) wait_drained();
      if ($urandom_range(0, 39) == 0) begin
        w = '0;
      end else begin
        w.antenna_state_0 = rand_state();
        w.antenna_state_1 = rand_state();
        w.antenna_state_2 = rand_state();
        w.antenna_state_3 = rand_state();
      end
      send_states(w);
    end
  endtask

  initial begin
    logic [2*RegW-1:0] thr_tab, rate_tab;
    int t, acc_t, acc_r;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // zero tables out of reset
    for (int k = 0; k < 12; k++) send_states(in_word_t'(directed_pats[k]));

    // realistic graded tables
    t = 100;
    for (int k = 0; k < TopState; k++) begin
      t = t * 7 / 5;
      thr_tab[FieldW*k +: FieldW]  = FieldW'(t);
      rate_tab[FieldW*k +: FieldW] = FieldW'(6500 * (k + 1));
    end
    load_tables(thr_tab, rate_tab);
    for (int k = 0; k < 12; k++) send_states(in_word_t'(directed_pats[k]));
    run_random(360, 1'b1);

    load_tables('1, '1);
    run_random(300, 1'b1);

    load_tables({$urandom, $urandom, $urandom, $urandom},
                {$urandom, $urandom, $urandom, $urandom});
    run_random(300, 1'b1);

    // tiny values, lots of ties
    for (int k = 0; k < TopState; k++) begin
      thr_tab[FieldW*k +: FieldW]  = FieldW'($urandom_range(0, 3));
      rate_tab[FieldW*k +: FieldW] = FieldW'($urandom_range(0, 3));
    end
    load_tables(thr_tab, rate_tab);
    run_random(300, 1'b1);

    load_tables('0, '0);
    run_random(100, 1'b1);

    // random monotonic tables, full throughput
    acc_t = 0;
    acc_r = 0;
    for (int k = 0; k < TopState; k++) begin
      acc_t += $urandom_range(0, 8191);
      acc_r += $urandom_range(0, 8191);
      thr_tab[FieldW*k +: FieldW]  = FieldW'(acc_t);
      rate_tab[FieldW*k +: FieldW] = FieldW'(acc_r);
    end
    load_tables(thr_tab, rate_tab);
    run_random(440, 1'b0);

    wait_drained();
    $display("%0d state words over %0d table loads; %0d choices checked, %0d mismatches",
             words_sent, loads, board.checked, board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("mimo_stream_and_mcs_select_unit verification clean");
    end else begin
      $display("mimo_stream_and_mcs_select_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== mimo_stream_and_mcs_select_unit.f =====
+incdir+src
src/msmcs_pkg.sv
src/mimo_stream_and_mcs_select_unit.sv
tb/mimo_stream_and_mcs_select_unit_tb.sv
